/* hw/rtl/tdre_pkg.sv */
// Shared constants, types and header helpers for the threshold delta run encoder.
`default_nettype none

package tdre_pkg;

  localparam int POSITION_BITS = 22;
  localparam int MAX_RUN       = 255;

  localparam int VARINT_GROUP  = 7;
  localparam int VARINT_MAX    = (POSITION_BITS + VARINT_GROUP - 1) / VARINT_GROUP;
  localparam int HDR_MAX       = VARINT_MAX + 1;
  localparam int PKT_MAX       = HDR_MAX + MAX_RUN;
  localparam int LANES         = 8;
  localparam int LANE_BITS     = $clog2(LANES);
  localparam int ROW_COUNT     = (PKT_MAX + LANES - 1) / LANES;
  localparam int ROW_BITS      = $clog2(ROW_COUNT);
  localparam int PTR_BITS      = $clog2(PKT_MAX + 1);
  localparam int LEN_BITS      = $clog2(MAX_RUN + 1);
  localparam int VLEN_BITS     = $clog2(VARINT_MAX + 1);
  localparam int COUNT_BITS    = 4;
  localparam int NUM_BANKS     = 2;
  localparam int MEM_DEPTH     = NUM_BANKS * (1 << ROW_BITS);
  localparam int FIFO_DEPTH    = 4;
  localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);

  localparam int SHORT_RUN     = 3;
  localparam logic [7:0] THRESHOLD_RESET = 8'd15;
  localparam logic [7:0] CLAMP_HI = 8'h7F;
  localparam logic [7:0] CLAMP_LO = 8'h80;
  localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

  // byte write into the packet staging memory
  typedef struct packed {
    logic                 we;
    logic                 bank;
    logic [ROW_BITS-1:0]  row;
    logic [LANE_BITS-1:0] lane;
    logic [7:0]           data;
  } mem_wr_t;

  // one closed packet (or a bare frame-done marker) handed to the back end
  typedef struct packed {
    logic                     has_pkt;
    logic                     frame_done;
    logic                     bank;
    logic [POSITION_BITS-1:0] start;
    logic [VLEN_BITS-1:0]     vlen;
    logic [LEN_BITS-1:0]      len;
  } desc_t;

  function automatic logic [VLEN_BITS-1:0] varint_len(input logic [POSITION_BITS-1:0] v);
    logic [VLEN_BITS-1:0] n;
    n = VLEN_BITS'(1);
    for (int k = 1; k < VARINT_MAX; k++) begin
      if ((v >> (VARINT_GROUP * k)) != '0) begin
        n = VLEN_BITS'(k + 1);
      end
    end
    return n;
  endfunction

  function automatic logic [7:0] varint_byte(input logic [POSITION_BITS-1:0] v, input int k,
                                             input logic [VLEN_BITS-1:0] vlen);
    logic [POSITION_BITS-1:0] sh;
    sh = v >> (VARINT_GROUP * k);
    return {(k < int'(vlen) - 1), sh[6:0]};
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/tdre_desc_fifo.sv */
// Small descriptor queue between the classifier and the packet builder.
`default_nettype none

module tdre_desc_fifo import tdre_pkg::*; (
  input  wire   clk,
  input  wire   rst_n,
  input  wire   push,
  input  desc_t push_desc,
  input  wire   pop,
  output desc_t head,
  output logic  empty,
  output logic  full
);

  desc_t                    slot_r [FIFO_DEPTH];
  logic [FIFO_PTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_PTR_BITS-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_PTR_BITS:0]   fill_r, fill_nxt;

  assign empty = (fill_r == '0);
  assign full  = (fill_r == (FIFO_PTR_BITS + 1)'(FIFO_DEPTH));
  assign head  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + FIFO_PTR_BITS'(push);
    rd_ptr_nxt = rd_ptr_r + FIFO_PTR_BITS'(pop);
    fill_nxt   = fill_r + (FIFO_PTR_BITS + 1)'(push) - (FIFO_PTR_BITS + 1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_desc;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/tdre_front.sv */
// Front end: threshold test, run tracking, delta staging writes and packet descriptors.
`default_nettype none

module tdre_front import tdre_pkg::*; (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  cfg_wr_en,
  input  wire  [7:0]           cfg_wr_data,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  wire  [7:0]           in_current_sample,
  input  wire  [7:0]           in_previous_sample,
  input  wire                  in_frame_end,
  output mem_wr_t              mem_wr,
  output desc_t                desc,
  output logic                 desc_push,
  input  wire                  fifo_full,
  input  wire  [NUM_BANKS-1:0] bank_release,
  output logic [NUM_BANKS-1:0] bank_busy
);

  logic [7:0]               thr_r;
  logic [POSITION_BITS-1:0] pos_r, pos_nxt;
  logic [POSITION_BITS-1:0] start_r, start_nxt;
  logic [VLEN_BITS-1:0]     vlen_r, vlen_nxt;
  logic [LEN_BITS-1:0]      len_r, len_nxt;
  logic                     open_r, open_nxt;
  logic                     bank_r, bank_nxt;
  logic [NUM_BANKS-1:0]     busy_r, busy_nxt;

  logic signed [8:0]        diff;
  logic [8:0]               abs_wide;
  logic [7:0]               abs_diff;
  logic                     changed;
  logic [7:0]               entry;
  logic                     do_open, append, close, need_push, accept;
  logic [POSITION_BITS-1:0] eff_start;
  logic [VLEN_BITS-1:0]     eff_vlen;
  logic [LEN_BITS-1:0]      eff_len, new_len;
  logic [PTR_BITS-1:0]      wptr;

  assign bank_busy = busy_r;

  always_comb begin
    diff     = $signed({1'b0, in_current_sample}) - $signed({1'b0, in_previous_sample});
    abs_wide = diff[8] ? 9'(-diff) : 9'(diff);
    abs_diff = abs_wide[7:0];
    changed  = (abs_diff >= thr_r);

    if (diff > 9'sd127) begin
      entry = CLAMP_HI;
    end else if (diff < -9'sd128) begin
      entry = CLAMP_LO;
    end else begin
      entry = diff[7:0];
    end

    do_open   = !open_r && changed;
    eff_start = do_open ? pos_r : start_r;
    eff_vlen  = do_open ? varint_len(pos_r) : vlen_r;
    eff_len   = do_open ? '0 : len_r;
    // short runs absorb unchanged bytes as zero deltas
    append    = do_open || (open_r && (changed || (len_r < LEN_BITS'(SHORT_RUN))));
    new_len   = eff_len + LEN_BITS'(append);
    close     = (open_r && !append) ||
                (append && (new_len == LEN_BITS'(MAX_RUN))) ||
                ((open_r || do_open) && in_frame_end);
    need_push = close || in_frame_end;

    in_ready  = !((do_open && busy_r[bank_r]) || (need_push && fifo_full));
    accept    = in_valid && in_ready;

    wptr = PTR_BITS'(eff_vlen) + PTR_BITS'(1) + PTR_BITS'(eff_len);
    mem_wr.we   = accept && append;
    mem_wr.bank = bank_r;
    mem_wr.row  = ROW_BITS'(wptr >> LANE_BITS);
    mem_wr.lane = wptr[LANE_BITS-1:0];
    mem_wr.data = changed ? entry : 8'h00;

    desc.has_pkt    = close;
    desc.frame_done = in_frame_end;
    desc.bank       = bank_r;
    desc.start      = eff_start;
    desc.vlen       = eff_vlen;
    desc.len        = new_len;
    desc_push       = accept && need_push;

    open_nxt  = open_r;
    start_nxt = start_r;
    vlen_nxt  = vlen_r;
    len_nxt   = len_r;
    bank_nxt  = bank_r;
    pos_nxt   = pos_r;
    busy_nxt  = busy_r & ~bank_release;
    if (accept) begin
      open_nxt  = (open_r || do_open) && !close;
      start_nxt = eff_start;
      vlen_nxt  = eff_vlen;
      len_nxt   = close ? '0 : new_len;
      if (close) begin
        bank_nxt         = !bank_r;
        busy_nxt[bank_r] = 1'b1;
      end
      if (in_frame_end) begin
        pos_nxt = '0;
      end else if (pos_r != POS_MAX) begin
        pos_nxt = pos_r + POSITION_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r   <= THRESHOLD_RESET;
      pos_r   <= '0;
      start_r <= '0;
      vlen_r  <= VLEN_BITS'(1);
      len_r   <= '0;
      open_r  <= 1'b0;
      bank_r  <= 1'b0;
      busy_r  <= '0;
    end else begin
      if (cfg_wr_en) begin
        thr_r <= cfg_wr_data;
      end
      pos_r   <= pos_nxt;
      start_r <= start_nxt;
      vlen_r  <= vlen_nxt;
      len_r   <= len_nxt;
      open_r  <= open_nxt;
      bank_r  <= bank_nxt;
      busy_r  <= busy_nxt;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/tdre_back.sv */
// Back end: staging memory, row sequencer and 8-byte word assembly.
`default_nettype none

module tdre_back import tdre_pkg::*; (
  input  wire                  clk,
  input  wire                  rst_n,
  input  mem_wr_t              mem_wr,
  input  desc_t                head,
  input  wire                  fifo_empty,
  output logic                 fifo_pop,
  output logic [NUM_BANKS-1:0] bank_release,
  output logic                 out_valid,
  input  wire                  out_ready,
  output logic [63:0]          out_packet_bytes,
  output logic [3:0]           out_byte_count,
  output logic                 out_packet_end,
  output logic                 out_frame_done
);

  typedef struct packed {
    logic                     row0;
    logic                     last;
    logic                     has_pkt;
    logic                     frame_done;
    logic [COUNT_BITS-1:0]    count;
    logic [POSITION_BITS-1:0] start;
    logic [VLEN_BITS-1:0]     vlen;
    logic [LEN_BITS-1:0]      len;
  } row_meta_t;

  logic [63:0]         delta_mem [MEM_DEPTH];
  logic [63:0]         rd_data_r;

  logic                active_r, active_nxt;
  desc_t               desc_r, desc_nxt;
  logic [ROW_BITS-1:0] row_r, row_nxt;

  logic                s1_valid_r, s1_valid_nxt;
  row_meta_t           s1_meta_r, s1_meta_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [63:0]         out_bytes_r, out_bytes_nxt;
  logic [3:0]          out_count_r, out_count_nxt;
  logic                out_end_r, out_end_nxt;
  logic                out_done_r, out_done_nxt;

  logic [PTR_BITS-1:0] total, rem;
  logic [ROW_BITS-1:0] last_row;
  logic                out_free, s1_adv, issue, issue_last;
  logic [7:0]          lane_byte;

  assign out_valid        = out_valid_r;
  assign out_packet_bytes = out_bytes_r;
  assign out_byte_count   = out_count_r;
  assign out_packet_end   = out_end_r;
  assign out_frame_done   = out_done_r;

  always_comb begin
    lane_byte = 8'h00;
    total    = PTR_BITS'(desc_r.vlen) + PTR_BITS'(1) + PTR_BITS'(desc_r.len);
    last_row = ROW_BITS'((total - PTR_BITS'(1)) >> LANE_BITS);
    rem      = total - PTR_BITS'({row_r, {LANE_BITS{1'b0}}});

    out_free   = !out_valid_r || out_ready;
    s1_adv     = s1_valid_r && out_free;
    issue      = active_r && (!s1_valid_r || s1_adv);
    issue_last = issue && (!desc_r.has_pkt || (row_r == last_row));
    fifo_pop   = !active_r && !fifo_empty;

    // the bank is free once its final row sits in the read register
    bank_release = '0;
    if (issue_last && desc_r.has_pkt) begin
      bank_release[desc_r.bank] = 1'b1;
    end

    active_nxt = active_r;
    desc_nxt   = desc_r;
    row_nxt    = row_r;
    if (fifo_pop) begin
      active_nxt = 1'b1;
      desc_nxt   = head;
      row_nxt    = '0;
    end else if (issue) begin
      row_nxt = row_r + ROW_BITS'(1);
      if (issue_last) begin
        active_nxt = 1'b0;
      end
    end

    s1_meta_nxt.row0       = (row_r == '0);
    s1_meta_nxt.last       = issue_last;
    s1_meta_nxt.has_pkt    = desc_r.has_pkt;
    s1_meta_nxt.frame_done = desc_r.frame_done;
    if (!desc_r.has_pkt) begin
      s1_meta_nxt.count = '0;
    end else if (rem >= PTR_BITS'(LANES)) begin
      s1_meta_nxt.count = COUNT_BITS'(LANES);
    end else begin
      s1_meta_nxt.count = COUNT_BITS'(rem);
    end
    s1_meta_nxt.start = desc_r.start;
    s1_meta_nxt.vlen  = desc_r.vlen;
    s1_meta_nxt.len   = desc_r.len;
    s1_valid_nxt      = issue || (s1_valid_r && !s1_adv);

    // word assembly: header overlays row 0, lanes past the count read zero
    out_bytes_nxt = out_bytes_r;
    out_count_nxt = out_count_r;
    out_end_nxt   = out_end_r;
    out_done_nxt  = out_done_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
      for (int b = 0; b < LANES; b++) begin
        lane_byte = rd_data_r[8*b +: 8];
        if (s1_meta_r.row0 && (b < int'(s1_meta_r.vlen))) begin
          lane_byte = varint_byte(s1_meta_r.start, b, s1_meta_r.vlen);
        end else if (s1_meta_r.row0 && (b == int'(s1_meta_r.vlen))) begin
          lane_byte = 8'(s1_meta_r.len);
        end
        if (b >= int'(s1_meta_r.count)) begin
          lane_byte = 8'h00;
        end
        out_bytes_nxt[8*b +: 8] = lane_byte;
      end
      out_count_nxt = s1_meta_r.count;
      out_end_nxt   = s1_meta_r.last && s1_meta_r.has_pkt;
      out_done_nxt  = s1_meta_r.last && s1_meta_r.frame_done;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_wr.we) begin
      for (int b = 0; b < LANES; b++) begin
        if (mem_wr.lane == LANE_BITS'(b)) begin
          delta_mem[{mem_wr.bank, mem_wr.row}][8*b +: 8] <= mem_wr.data;
        end
      end
    end
    if (issue) begin
      rd_data_r <= delta_mem[{desc_r.bank, row_r}];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      active_r    <= active_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    desc_r      <= desc_nxt;
    row_r       <= row_nxt;
    out_bytes_r <= out_bytes_nxt;
    out_count_r <= out_count_nxt;
    out_end_r   <= out_end_nxt;
    out_done_r  <= out_done_nxt;
    if (issue) begin
      s1_meta_r <= s1_meta_nxt;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/threshold_delta_run_encoder.sv */
// Top level of the threshold delta run encoder: front end, descriptor queue, back end.
`default_nettype none

// Takes one current/previous frame byte pair per beat and emits change packets
// (LEB128 start position, length byte, clamped deltas) as 8-byte result beats.
// The front end accepts one input beat per cycle; deltas are written straight
// into a two-bank staging memory at their final packet offset, so each closed
// run costs the back end ceil((varint_len + 1 + run_length) / 8) output beats
// plus one descriptor load. Input stalls only when a new run
// must open while both banks still hold packets not yet read out, or when a
// packet or frame marker has to be queued and the 4-entry descriptor queue is
// full. A frame_end beat that closes no packet produces one empty beat with
// out_frame_done set. The change threshold is written through cfg_wr_en /
// cfg_wr_data (reset value 15) and must only change while the block is idle.
// Reset is synchronous; the staging memory needs no clearing pass.

module threshold_delta_run_encoder import tdre_pkg::*; (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         cfg_wr_en,
  input  wire  [7:0]  cfg_wr_data,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire  [7:0]  in_current_sample,
  input  wire  [7:0]  in_previous_sample,
  input  wire         in_frame_end,
  output logic        out_valid,
  input  wire         out_ready,
  output logic [63:0] out_packet_bytes,
  output logic [3:0]  out_byte_count,
  output logic        out_packet_end,
  output logic        out_frame_done
);

  mem_wr_t              mem_wr;
  desc_t                push_desc;
  desc_t                head_desc;
  logic                 desc_push;
  logic                 fifo_pop;
  logic                 fifo_empty;
  logic                 fifo_full;
  logic [NUM_BANKS-1:0] bank_release;
  logic [NUM_BANKS-1:0] bank_busy;

  // classify bytes, track the open run, stage deltas
  tdre_front u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_current_sample  (in_current_sample),
    .in_previous_sample (in_previous_sample),
    .in_frame_end       (in_frame_end),
    .mem_wr             (mem_wr),
    .desc               (push_desc),
    .desc_push          (desc_push),
    .fifo_full          (fifo_full),
    .bank_release       (bank_release),
    .bank_busy          (bank_busy)
  );

  // closed packets and frame markers wait here
  tdre_desc_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (desc_push),
    .push_desc (push_desc),
    .pop       (fifo_pop),
    .head      (head_desc),
    .empty     (fifo_empty),
    .full      (fifo_full)
  );

  // read staged rows and build output beats
  tdre_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .mem_wr           (mem_wr),
    .head             (head_desc),
    .fifo_empty       (fifo_empty),
    .fifo_pop         (fifo_pop),
    .bank_release     (bank_release),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_packet_bytes (out_packet_bytes),
    .out_byte_count   (out_byte_count),
    .out_packet_end   (out_packet_end),
    .out_frame_done   (out_frame_done)
  );

  // a beat that does not end a packet is full, or is the empty frame marker
  a_mid_word_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_packet_end |->
      (out_byte_count == COUNT_BITS'(LANES)) || ((out_byte_count == '0) && out_frame_done))
    else $error("short beat before end of packet");

  // the last beat of a packet carries at least one byte
  a_end_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_packet_end |-> out_byte_count != '0)
    else $error("empty beat flagged as packet end");

  // the front end never overwrites a bank still waiting to be read out
  a_no_busy_write: assert property (@(posedge clk) disable iff (!rst_n)
    mem_wr.we |-> !bank_busy[mem_wr.bank])
    else $error("write into a busy staging bank");

  // the back end only frees banks that are held
  a_release_held: assert property (@(posedge clk) disable iff (!rst_n)
    bank_release != '0 |-> (bank_release & ~bank_busy) == '0)
    else $error("release of a free staging bank");

endmodule

`default_nettype wire
